@@ rtl/oik_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Omni base inverse kinematics: shared definitions
// Word widths, CORDIC angle table and the beat format of the CORDIC chain.
// ----------------------------------------------------------------------------
package oik_pkg;

  localparam int CORDIC_STAGES = 14;
  localparam int ANGLE_TAB_LEN = 24;
  localparam int STAGE_W       = $clog2(ANGLE_TAB_LEN);
  localparam int CW            = 32;
  localparam int LATENCY       = CORDIC_STAGES + 6;

  localparam logic signed [CW-1:0] CORDIC_X0      = 32'sd652032874;
  localparam logic [16:0]          SQRT3_HALF_Q16 = 17'd56756;
  localparam logic [11:0]          WHEEL_BASE_RST = 12'd512;

  typedef logic signed [CW-1:0] cword_t;

  typedef struct packed {
    cword_t             x;
    cword_t             y;
    cword_t             z;
    logic [1:0]         quad;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] tr;
  } cbeat_t;

  function automatic cword_t angle_of(input logic [STAGE_W-1:0] idx);
    cword_t a;
    case (idx)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10680862;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41722;
      5'd15:   a = 32'sd20861;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      5'd18:   a = 32'sd2608;
      5'd19:   a = 32'sd1304;
      5'd20:   a = 32'sd652;
      5'd21:   a = 32'sd326;
      5'd22:   a = 32'sd163;
      5'd23:   a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/oik_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Omni base inverse kinematics: CORDIC cell
// One rotation-mode micro-rotation, registered, handed on to the next cell.
// ----------------------------------------------------------------------------
module oik_cordic_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [oik_pkg::STAGE_W-1:0]  stage_i,
  input  logic                         vld_i,
  input  oik_pkg::cbeat_t              beat_i,
  output logic                         vld_o,
  output oik_pkg::cbeat_t              beat_o
);
  import oik_pkg::*;

  cword_t x_sh, y_sh, ang;
  cbeat_t beat_d, beat_q;
  logic   vld_q;

  always_comb begin
    x_sh   = $signed(beat_i.x) >>> stage_i;
    y_sh   = $signed(beat_i.y) >>> stage_i;
    ang    = angle_of(stage_i);
    beat_d = beat_i;
    if (!beat_i.z[CW-1]) begin
      beat_d.x = beat_i.x - y_sh;
      beat_d.y = beat_i.y + x_sh;
      beat_d.z = beat_i.z - ang;
    end else begin
      beat_d.x = beat_i.x + y_sh;
      beat_d.y = beat_i.y - x_sh;
      beat_d.z = beat_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign vld_o  = vld_q;
  assign beat_o = beat_q;

endmodule

@@ rtl/oik_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Omni base inverse kinematics: body rotation and wheel mixer
// Quadrant fix-up, body-frame rotation, turn term and wheel sums in five stages.
// ----------------------------------------------------------------------------
module oik_mixer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  oik_pkg::cbeat_t      beat_i,
  input  logic [11:0]          wheel_base_i,
  output logic                 done_o,
  output logic signed [17:0]   wheel_left_o,
  output logic signed [17:0]   wheel_back_o,
  output logic signed [17:0]   wheel_right_o
);
  import oik_pkg::*;

  function automatic logic signed [17:0] sat18(input logic signed [22:0] v);
    logic signed [17:0] r;
    if (v > 23'sd131071) begin
      r = 18'sd131071;
    end else if (v < -23'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  logic [4:0] vld_q;

  // Stage 1: cosine and sine of the full heading.
  cword_t             c_d, s_d, c1_q, s1_q;
  logic signed [15:0] vx1_q, vy1_q, tr1_q;

  // Stage 2: products.
  logic signed [47:0] p_cx_q, p_sy_q, p_cy_q, p_sx_q;
  logic signed [28:0] p_tw_q;

  // Stage 3: body speeds and turn term.
  logic signed [48:0] sum_x, sum_y;
  logic signed [28:0] sum_w;
  logic signed [22:0] vxm3_q, vym3_q;
  logic signed [24:0] wl3_q;

  // Stage 4: sqrt(3)/2 product.
  logic signed [40:0] p_ys_q;
  logic signed [22:0] vxm4_q;
  logic signed [24:0] wl4_q;

  // Stage 5: wheel sums.
  logic signed [40:0] sum_ys;
  logic signed [24:0] ys;
  logic signed [27:0] wl_x, vxm_x, ys_x, left, back, right;
  logic signed [17:0] left_q, back_q, right_q;

  always_comb begin
    case (beat_i.quad)
      2'd0: begin
        c_d = beat_i.x;
        s_d = beat_i.y;
      end
      2'd1: begin
        c_d = -beat_i.y;
        s_d = beat_i.x;
      end
      2'd2: begin
        c_d = -beat_i.x;
        s_d = -beat_i.y;
      end
      default: begin
        c_d = beat_i.y;
        s_d = -beat_i.x;
      end
    endcase
  end

  always_comb begin
    sum_x = 49'(p_cx_q) + 49'(p_sy_q) + 49'sd33554432;
    sum_y = 49'(p_cy_q) - 49'(p_sx_q) + 49'sd33554432;
    sum_w = p_tw_q + 29'sd8;
  end

  always_comb begin
    sum_ys = p_ys_q + 41'sd32768;
    ys     = sum_ys[40:16];
    wl_x   = 28'(wl4_q);
    vxm_x  = 28'(vxm4_q);
    ys_x   = 28'(ys);
    left   = (wl_x <<< 1) + 28'sd16 - vxm_x - (ys_x <<< 1);
    back   = (wl_x <<< 1) + 28'sd16 + (vxm_x <<< 1);
    right  = (wl_x <<< 1) + 28'sd16 - vxm_x + (ys_x <<< 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q    <= c_d;
    s1_q    <= s_d;
    vx1_q   <= beat_i.vx;
    vy1_q   <= beat_i.vy;
    tr1_q   <= beat_i.tr;

    p_cx_q  <= 48'(c1_q) * 48'(vx1_q);
    p_sy_q  <= 48'(s1_q) * 48'(vy1_q);
    p_cy_q  <= 48'(c1_q) * 48'(vy1_q);
    p_sx_q  <= 48'(s1_q) * 48'(vx1_q);
    p_tw_q  <= 29'(tr1_q) * 29'($signed({1'b0, wheel_base_i}));

    vxm3_q  <= sum_x[48:26];
    vym3_q  <= sum_y[48:26];
    wl3_q   <= sum_w[28:4];

    p_ys_q  <= 41'(vym3_q) * 41'($signed({1'b0, SQRT3_HALF_Q16}));
    vxm4_q  <= vxm3_q;
    wl4_q   <= wl3_q;

    left_q  <= sat18(left[27:5]);
    back_q  <= sat18(back[27:5]);
    right_q <= sat18(right[27:5]);
  end

  assign done_o        = vld_q[4];
  assign wheel_left_o  = left_q;
  assign wheel_back_o  = back_q;
  assign wheel_right_o = right_q;

endmodule

@@ rtl/omni_inverse_kinematics_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Omni base inverse kinematics: top level
// World-frame velocity command to three omni wheel rim speeds.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 beat
//  command   in         start high, busy low      vel_x/vel_y/turn_rate/heading
//  wheels    out        done_o strobe, one cycle  wheel_left/back/right
//  config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (wheel base)
//
// A command beat can be taken in every cycle; busy stays low.
// Each beat passes through CORDIC_STAGES cells plus six stages: the input
// register ahead of the CORDIC cell chain and the mixer pipeline behind it.
// Reset clears all valid bits and loads the wheel base with 0.125 m.
// The receiver cannot stall, so nothing is held back inside.
// ----------------------------------------------------------------------------
module omni_inverse_kinematics_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  vel_x_world_i,
  input  logic signed [15:0]  vel_y_world_i,
  input  logic signed [15:0]  turn_rate_i,
  input  logic [15:0]         heading_i,
  output logic                done_o,
  output logic signed [17:0]  wheel_left_o,
  output logic signed [17:0]  wheel_back_o,
  output logic signed [17:0]  wheel_right_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [11:0]         cfg_data_i
);
  import oik_pkg::*;

  logic [11:0] wb_q;
  logic [15:0] h_sum, resid;
  cbeat_t      beat_d;
  logic        vld_c  [CORDIC_STAGES+1];
  cbeat_t      beat_c [CORDIC_STAGES+1];
  logic        vld0_q;
  cbeat_t      beat0_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    h_sum       = heading_i + 16'd8192;
    beat_d.quad = h_sum[15:14];
    resid       = heading_i - {beat_d.quad, 14'd0};
    beat_d.z    = $signed({resid, 16'd0});
    beat_d.x    = CORDIC_X0;
    beat_d.y    = '0;
    beat_d.vx   = vel_x_world_i;
    beat_d.vy   = vel_y_world_i;
    beat_d.tr   = turn_rate_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      wb_q   <= WHEEL_BASE_RST;
    end else begin
      vld0_q <= start && !busy;
      if (cfg_valid_i && cfg_ready_o) begin
        wb_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    beat0_q <= beat_d;
  end

  assign vld_c[0]  = vld0_q;
  assign beat_c[0] = beat0_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    oik_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .stage_i(STAGE_W'(g)),
      .vld_i  (vld_c[g]),
      .beat_i (beat_c[g]),
      .vld_o  (vld_c[g+1]),
      .beat_o (beat_c[g+1])
    );
  end

  oik_mixer u_mixer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vld_i        (vld_c[CORDIC_STAGES]),
    .beat_i       (beat_c[CORDIC_STAGES]),
    .wheel_base_i (wb_q),
    .done_o       (done_o),
    .wheel_left_o (wheel_left_o),
    .wheel_back_o (wheel_back_o),
    .wheel_right_o(wheel_right_o)
  );

`ifndef ASSERT_OFF
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted command beat did not leave on time");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("wheel beat without a matching command beat");

  a_zero_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start && !busy && vel_x_world_i == 16'sd0 && vel_y_world_i == 16'sd0
          && turn_rate_i == 16'sd0, LATENCY)
    |-> (wheel_left_o == 18'sd0 && wheel_back_o == 18'sd0 && wheel_right_o == 18'sd0))
    else $error("zero command gave nonzero wheel speeds");
`endif

endmodule
